// ----- rtl/core/tatlc_pkg.sv -----
// shared types, constants and level lookup functions for the tilt to led color unit
package tatlc_pkg;

    localparam int LEVELS   = 20;
    localparam int FRAC_Q   = 24;
    localparam int THRESH_W = FRAC_Q + 1;
    localparam int LEVEL_W  = 5;
    localparam int FIELD_W  = 16;

    // cosine thresholds in Q24, cos(18 * ln(20/j) deg) for j = 1..20
    localparam logic [THRESH_W-1:0] COS_THRESH [LEVELS] = '{
        25'd9879589,  25'd12575761, 25'd13884636, 25'd14677957, 25'd15211096,
        25'd15591340, 25'd15872982, 25'd16086888, 25'd16252083, 25'd16381008,
        25'd16482178, 25'd16561639, 25'd16623810, 25'd16672000, 25'd16708743,
        25'd16736008, 25'd16755353, 25'd16768026, 25'd16775038, 25'd16777216
    };

    // squaring phase counter value that selects each axis
    localparam logic [1:0] AXIS_X = 2'd3;
    localparam logic [1:0] AXIS_Y = 2'd2;
    localparam logic [1:0] AXIS_Z = 2'd1;

    localparam logic MODE_INTENSITY = 1'b0;
    localparam logic MODE_COLOR     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] sq_axis;
        logic       acc_en;
        logic       root_step;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    // count of thresholds at or below the cosine
    function automatic logic [LEVEL_W-1:0] level_near(input logic [THRESH_W-1:0] c);
        logic [LEVEL_W-1:0] n;
        n = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if (c >= COS_THRESH[j]) begin
                n = n + LEVEL_W'(1);
            end
        end
        return n;
    endfunction

    // count of thresholds at or above the cosine, last one excluded
    function automatic logic [LEVEL_W-1:0] level_far(input logic [THRESH_W-1:0] c);
        logic [LEVEL_W-1:0] n;
        n = '0;
        for (int j = 0; j < LEVELS - 1; j++) begin
            if (c <= COS_THRESH[j]) begin
                n = n + LEVEL_W'(1);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/tilt_angle_to_led_color_unit.sv -----
// top level of the tilt angle to led color unit
// Takes one accelerometer word (x, y, z and a button flag) and returns one
// color word (red, green, blue levels 0..20 and the display mode used).
// A button press toggles between intensity mode and color mode before the
// sample is used; the mode resets to intensity. For each axis the unit forms
// the direction cosine |a| / |v| with COS_BITS fraction bits and maps it to a
// level through twenty cosine thresholds; an all-zero sample gives black.
// One word is worked at a time: an accepted word passes through the
// shared squarer, the bit-serial square root and the three parallel
// restoring divider lanes, then loads the output register. A new word is
// not taken before the last one has loaded the output register, and that
// load waits until the previous result has been taken. The output register
// holds a finished result while the next word is already being worked.
module tilt_angle_to_led_color_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int COS_BITS    = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input word
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]  s_accel_x,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]  s_accel_y,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]  s_accel_z,
    input  logic                                  s_button_pressed,
    // result word
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tatlc_pkg::LEVEL_W-1:0]         m_red,
    output logic [tatlc_pkg::LEVEL_W-1:0]         m_green,
    output logic [tatlc_pkg::LEVEL_W-1:0]         m_blue,
    output logic                                  m_display_mode
);

    // command bundle from controller to datapath
    tatlc_pkg::cmd_t cmd;

    // sequencer: phase counter and output handshake
    tatlc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COS_BITS    (COS_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // magnitude, cosines and level lookup
    tatlc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COS_BITS    (COS_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_accel_x        (s_accel_x),
        .s_accel_y        (s_accel_y),
        .s_accel_z        (s_accel_z),
        .s_button_pressed (s_button_pressed),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_display_mode   (m_display_mode)
    );

    // an accepted word keeps the unit busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // levels never exceed the top of the scale
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red <= 5'd20 && m_green <= 5'd20 && m_blue <= 5'd20))
        else $error("level out of range");

    // intensity mode drives all three channels alike
    a_intensity_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_display_mode == tatlc_pkg::MODE_INTENSITY)
            |-> (m_red == m_green && m_green == m_blue))
        else $error("intensity mode channels differ");

endmodule

// ----- rtl/core/tatlc_ctrl.sv -----
// controller state machine sequencing square, root, divide and output phases
module tatlc_ctrl #(
    parameter int SAMPLE_BITS = 16,
    parameter int COS_BITS    = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tatlc_pkg::cmd_t     cmd
);

    localparam int SQ_STEPS  = 4;
    localparam int DIV_STEPS = COS_BITS + 1;
    localparam int MAX_A     = (SAMPLE_BITS > DIV_STEPS) ? SAMPLE_BITS : DIV_STEPS;
    localparam int STEPS_MAX = (MAX_A > SQ_STEPS) ? MAX_A : SQ_STEPS;
    localparam int CNT_W     = $clog2(STEPS_MAX);

    tatlc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              cnt_zero;
    logic              out_free;

    assign cnt_zero = (cnt_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tatlc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and phase counter
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            tatlc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tatlc_pkg::ST_SQUARE;
                    cnt_next   = CNT_W'(SQ_STEPS - 1);
                end
            end
            tatlc_pkg::ST_SQUARE: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_zero) begin
                    state_next = tatlc_pkg::ST_ROOT;
                    cnt_next   = CNT_W'(SAMPLE_BITS - 1);
                end
            end
            tatlc_pkg::ST_ROOT: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_zero) begin
                    state_next = tatlc_pkg::ST_DIVIDE;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                end
            end
            tatlc_pkg::ST_DIVIDE: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_zero) begin
                    state_next = tatlc_pkg::ST_OUTPUT;
                    cnt_next   = '0;
                end
            end
            tatlc_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    state_next = tatlc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tatlc_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // datapath commands and handshake outputs
    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        unique case (state_reg)
            tatlc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tatlc_pkg::ST_SQUARE: begin
                cmd.mul_en  = !cnt_zero;
                cmd.sq_axis = cnt_reg[1:0];
                cmd.acc_en  = (cnt_reg != CNT_W'(SQ_STEPS - 1));
            end
            tatlc_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
            end
            tatlc_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            tatlc_pkg::ST_OUTPUT: begin
                cmd.out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/tatlc_datapath.sv -----
// datapath: abs, shared squarer, bit-serial square root, three divider lanes, level map
module tatlc_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int COS_BITS    = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tatlc_pkg::cmd_t                        cmd,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]   s_accel_x,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]   s_accel_y,
    input  logic signed [tatlc_pkg::FIELD_W-1:0]   s_accel_z,
    input  logic                                   s_button_pressed,
    output logic [tatlc_pkg::LEVEL_W-1:0]          m_red,
    output logic [tatlc_pkg::LEVEL_W-1:0]          m_green,
    output logic [tatlc_pkg::LEVEL_W-1:0]          m_blue,
    output logic                                   m_display_mode
);

    localparam int SB = SAMPLE_BITS;
    localparam int SW = 2 * SAMPLE_BITS;
    localparam int RW = SAMPLE_BITS + 3;
    localparam int QW = COS_BITS + 1;
    localparam int TW = tatlc_pkg::THRESH_W;
    localparam int LW = tatlc_pkg::LEVEL_W;

    function automatic logic [SB-1:0] abs_val(input logic [SB-1:0] v);
        return v[SB-1] ? (~v + SB'(1)) : v;
    endfunction

    logic [SB-1:0] raw_x, raw_y, raw_z;

    generate
        if (SAMPLE_BITS <= tatlc_pkg::FIELD_W) begin : g_trunc
            assign raw_x = s_accel_x[SB-1:0];
            assign raw_y = s_accel_y[SB-1:0];
            assign raw_z = s_accel_z[SB-1:0];
        end else begin : g_ext
            assign raw_x = {{(SB - tatlc_pkg::FIELD_W){1'b0}}, s_accel_x};
            assign raw_y = {{(SB - tatlc_pkg::FIELD_W){1'b0}}, s_accel_y};
            assign raw_z = {{(SB - tatlc_pkg::FIELD_W){1'b0}}, s_accel_z};
        end
    endgenerate

    logic          mode_reg, mode_next;
    logic [SB-1:0] abs_reg [3];
    logic [SW-1:0] prod_reg, acc_reg, acc_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [SB-1:0] root_reg, root_next;
    logic [SB:0]   div_r_reg [3];
    logic [SB:0]   div_r_next [3];
    logic [QW-1:0] div_q_reg [3];
    logic [QW-1:0] div_q_next [3];
    logic [LW-1:0] red_reg, green_reg, blue_reg;
    logic          disp_reg;

    logic [SB-1:0] mul_op;
    logic [RW-1:0] rem_sh, trial;
    logic [LW-1:0] lvl_near, lvl_far_x, lvl_far_y;
    logic [LW-1:0] red_next, green_next, blue_next;
    logic          mag_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tatlc_pkg::MODE_INTENSITY;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign mode_next = cmd.load ? (mode_reg ^ s_button_pressed) : mode_reg;

    // squarer operand select
    always_comb begin
        case (cmd.sq_axis)
            tatlc_pkg::AXIS_X: mul_op = abs_reg[0];
            tatlc_pkg::AXIS_Y: mul_op = abs_reg[1];
            tatlc_pkg::AXIS_Z: mul_op = abs_reg[2];
            default:           mul_op = '0;
        endcase
    end

    // restoring square root, one result bit per step
    assign rem_sh = {rem_reg[RW-3:0], acc_reg[SW-1:SW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        acc_next  = acc_reg;
        if (cmd.load) begin
            rem_next  = '0;
            root_next = '0;
            acc_next  = '0;
        end else if (cmd.acc_en) begin
            acc_next = acc_reg + prod_reg;
        end else if (cmd.root_step) begin
            acc_next = {acc_reg[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[SB-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[SB-2:0], 1'b0};
            end
        end
    end

    // restoring divide of |a| * 2^COS_BITS by the magnitude, three lanes
    always_comb begin
        logic [SB:0] t;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
            div_r_next[i] = div_r_reg[i];
            div_q_next[i] = div_q_reg[i];
            ge            = (div_r_reg[i] >= {1'b0, root_reg});
            t             = ge ? (div_r_reg[i] - {1'b0, root_reg}) : div_r_reg[i];
            if (cmd.div_step) begin
                div_r_next[i] = {t[SB-1:0], 1'b0};
                div_q_next[i] = {div_q_reg[i][QW-2:0], ge};
            end
        end
        if (cmd.load) begin
            div_r_next[0] = {1'b0, abs_val(raw_x)};
            div_r_next[1] = {1'b0, abs_val(raw_y)};
            div_r_next[2] = {1'b0, abs_val(raw_z)};
            for (int i = 0; i < 3; i++) begin
                div_q_next[i] = '0;
            end
        end
    end

    // level map
    assign mag_zero  = (root_reg == '0);
    assign lvl_near  = tatlc_pkg::level_near(TW'(div_q_reg[2]) << (tatlc_pkg::FRAC_Q - COS_BITS));
    assign lvl_far_x = tatlc_pkg::level_far(TW'(div_q_reg[0]) << (tatlc_pkg::FRAC_Q - COS_BITS));
    assign lvl_far_y = tatlc_pkg::level_far(TW'(div_q_reg[1]) << (tatlc_pkg::FRAC_Q - COS_BITS));

    always_comb begin
        if (mag_zero) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end else if (mode_reg == tatlc_pkg::MODE_COLOR) begin
            red_next   = lvl_far_x;
            green_next = lvl_far_y;
            blue_next  = lvl_near;
        end else begin
            red_next   = lvl_near;
            green_next = lvl_near;
            blue_next  = lvl_near;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            abs_reg[0] <= abs_val(raw_x);
            abs_reg[1] <= abs_val(raw_y);
            abs_reg[2] <= abs_val(raw_z);
        end
        if (cmd.mul_en) begin
            // operands widened first so the square keeps all its bits
            prod_reg <= SW'(mul_op) * SW'(mul_op);
        end
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        for (int i = 0; i < 3; i++) begin
            div_r_reg[i] <= div_r_next[i];
            div_q_reg[i] <= div_q_next[i];
        end
        if (cmd.out_load) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            disp_reg  <= mode_reg;
        end
    end

    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_display_mode = disp_reg;

endmodule
